// ===== hdl/ucal_pkg.sv =====
`timescale 1ns / 1ps

package ucal_pkg;

    localparam int SECS_W  = 39;
    localparam int DAY_W   = 22;
    localparam int TOD_W   = 17;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // Accepted range: 0001-01-01 00:00:00 through 9999-12-31 23:59:59.
    localparam logic signed [SECS_W-1:0] MIN_SECONDS = -39'sd62135596800;
    localparam logic signed [SECS_W-1:0] MAX_SECONDS = 39'sd253402300799;
    // Whole days from 0001-01-01 to 1970-01-01, in seconds.
    localparam logic [SECS_W-1:0] SECS_OFFSET = 39'd62135596800;

    // Days from 0000-03-01 to 0001-01-01.
    localparam logic [DAY_W-1:0] Z_OFFSET      = 22'd306;
    localparam logic [DAY_W-1:0] DAYS_PER_ERA  = 22'd146097;
    localparam logic [17:0]      LAST_DOE      = 18'd146096;

    // Reciprocals for exact division by constants: with K set to the operand
    // width plus the divisor width, floor(v * ceil(2^K / d) / 2^K) equals v / d.
    localparam int SHIFT_675   = 42;
    localparam int SHIFT_60S   = 23;
    localparam int SHIFT_60M   = 17;
    localparam int SHIFT_ERA   = 40;
    localparam int SHIFT_1460  = 29;
    localparam int SHIFT_36524 = 34;
    localparam int SHIFT_365   = 27;
    localparam int SHIFT_100   = 16;
    localparam int SHIFT_153   = 19;

    localparam logic [32:0] RECIP_675 =
        33'(((64'd1 << SHIFT_675) + 64'd674) / 64'd675);
    localparam logic [17:0] RECIP_60S =
        18'(((64'd1 << SHIFT_60S) + 64'd59) / 64'd60);
    localparam logic [11:0] RECIP_60M =
        12'(((64'd1 << SHIFT_60M) + 64'd59) / 64'd60);
    localparam logic [22:0] RECIP_ERA =
        23'(((64'd1 << SHIFT_ERA) + 64'd146096) / 64'd146097);
    localparam logic [18:0] RECIP_1460 =
        19'(((64'd1 << SHIFT_1460) + 64'd1459) / 64'd1460);
    localparam logic [18:0] RECIP_36524 =
        19'(((64'd1 << SHIFT_36524) + 64'd36523) / 64'd36524);
    localparam logic [18:0] RECIP_365 =
        19'(((64'd1 << SHIFT_365) + 64'd364) / 64'd365);
    localparam logic [9:0] RECIP_100 =
        10'(((64'd1 << SHIFT_100) + 64'd99) / 64'd100);
    localparam logic [11:0] RECIP_153 =
        12'(((64'd1 << SHIFT_153) + 64'd152) / 64'd153);

    typedef struct packed {
        logic             ok;
        logic [DAY_W-1:0] day;
        logic [TOD_W-1:0] tod;
    } day_tod_t;

    typedef struct packed {
        logic              ok;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
    } hms_t;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        hms_t             hms;
    } day_hms_t;

    typedef struct packed {
        logic               ok;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DOM_W-1:0]   dom;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } cal_t;

    // Day of the March-based year on which month index mp begins.
    function automatic logic [8:0] month_first_doy(input logic [3:0] mp);
        logic [8:0] doy;
        case (mp)
            4'd0:    doy = 9'd0;
            4'd1:    doy = 9'd31;
            4'd2:    doy = 9'd61;
            4'd3:    doy = 9'd92;
            4'd4:    doy = 9'd122;
            4'd5:    doy = 9'd153;
            4'd6:    doy = 9'd184;
            4'd7:    doy = 9'd214;
            4'd8:    doy = 9'd245;
            4'd9:    doy = 9'd275;
            4'd10:   doy = 9'd306;
            4'd11:   doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

// ===== hdl/ucal_day_split.sv =====
`timescale 1ns / 1ps

module ucal_day_split (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         src_valid,
    output logic                         src_stall,
    input  logic signed [ucal_pkg::SECS_W-1:0] unix_seconds,
    output logic                         dst_valid,
    input  logic                         dst_stall,
    output ucal_pkg::day_tod_t           dst_data
);
    import ucal_pkg::*;

    localparam int N = 3;

    logic [N-1:0] vld_reg;
    logic [N-1:0] adv;

    logic [SECS_W-1:0] shifted;
    logic              ok_a_next;
    logic              ok_a_reg;
    logic [31:0]       hi_a_reg;
    logic [6:0]        lo_a_reg;

    logic [64:0]      prod_b;
    logic [DAY_W-1:0] q_b_next;
    logic             ok_b_reg;
    logic [DAY_W-1:0] q_b_reg;
    logic [9:0]       hl_b_reg;
    logic [6:0]       lo_b_reg;

    logic [9:0] qm_c;
    logic [9:0] rem_c;
    day_tod_t   out_next;
    day_tod_t   out_reg;

    always_comb
    begin
        adv[N-1] = !vld_reg[N-1] || !dst_stall;
        for (int i = N - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign src_stall = !adv[0];
    assign dst_valid = vld_reg[N-1];
    assign dst_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= src_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Seconds counted from 0001-01-01; 86400 = 128 * 675, so the low seven
    // bits pass straight into the time of day.
    assign shifted   = unsigned'(unix_seconds) + SECS_OFFSET;
    assign ok_a_next = (unix_seconds >= MIN_SECONDS) && (unix_seconds <= MAX_SECONDS);

    assign prod_b   = 65'(hi_a_reg) * 65'(RECIP_675);
    assign q_b_next = prod_b[SHIFT_675 +: DAY_W];

    // The remainder is below 675, so ten bits of arithmetic are enough.
    assign qm_c  = 10'(q_b_reg[9:0] * 10'd675);
    assign rem_c = hl_b_reg - qm_c;

    always_comb
    begin
        out_next.ok  = ok_b_reg;
        out_next.day = q_b_reg;
        out_next.tod = {rem_c, lo_b_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ok_a_reg <= ok_a_next;
            hi_a_reg <= shifted[SECS_W-1:7];
            lo_a_reg <= shifted[6:0];
        end
        if (adv[1])
        begin
            ok_b_reg <= ok_a_reg;
            q_b_reg  <= q_b_next;
            hl_b_reg <= hi_a_reg[9:0];
            lo_b_reg <= lo_a_reg;
        end
        if (adv[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hdl/ucal_hms.sv =====
`timescale 1ns / 1ps

module ucal_hms (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  ucal_pkg::day_tod_t src_data,
    output logic               dst_valid,
    input  logic               dst_stall,
    output ucal_pkg::day_hms_t dst_data
);
    import ucal_pkg::*;

    localparam int N = 3;

    logic [N-1:0] vld_reg;
    logic [N-1:0] adv;

    logic [34:0]      prod_0;
    logic             ok_0_reg;
    logic [DAY_W-1:0] day_0_reg;
    logic [10:0]      mt_0_reg;
    logic [5:0]       ts_0_reg;

    logic [22:0]       prod_1;
    logic [5:0]        sec_1_next;
    logic              ok_1_reg;
    logic [DAY_W-1:0]  day_1_reg;
    logic [HOUR_W-1:0] hr_1_reg;
    logic [5:0]        mt_1_reg;
    logic [SEC_W-1:0]  sec_1_reg;

    logic [5:0] hm_2;
    day_hms_t   out_next;
    day_hms_t   out_reg;

    always_comb
    begin
        adv[N-1] = !vld_reg[N-1] || !dst_stall;
        for (int i = N - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign src_stall = !adv[0];
    assign dst_valid = vld_reg[N-1];
    assign dst_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= src_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Minutes of the day, then seconds and hours from that; each remainder is
    // below 64, so only the low six bits are computed.
    assign prod_0     = 35'(src_data.tod) * 35'(RECIP_60S);
    assign sec_1_next = ts_0_reg - 6'(mt_0_reg[5:0] * 6'd60);
    assign prod_1     = 23'(mt_0_reg) * 23'(RECIP_60M);
    assign hm_2       = 6'(6'(hr_1_reg) * 6'd60);

    always_comb
    begin
        out_next.day        = day_1_reg;
        out_next.hms.ok     = ok_1_reg;
        out_next.hms.hour   = hr_1_reg;
        out_next.hms.minute = mt_1_reg - hm_2;
        out_next.hms.second = sec_1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ok_0_reg  <= src_data.ok;
            day_0_reg <= src_data.day;
            mt_0_reg  <= prod_0[SHIFT_60S +: 11];
            ts_0_reg  <= src_data.tod[5:0];
        end
        if (adv[1])
        begin
            ok_1_reg  <= ok_0_reg;
            day_1_reg <= day_0_reg;
            hr_1_reg  <= prod_1[SHIFT_60M +: HOUR_W];
            mt_1_reg  <= mt_0_reg[5:0];
            sec_1_reg <= sec_1_next;
        end
        if (adv[2])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hdl/ucal_civil.sv =====
`timescale 1ns / 1ps

module ucal_civil (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  ucal_pkg::day_hms_t src_data,
    output logic               dst_valid,
    input  logic               dst_stall,
    output ucal_pkg::cal_t     dst_data
);
    import ucal_pkg::*;

    localparam int N = 9;

    logic [N-1:0] vld_reg;
    logic [N-1:0] adv;

    // Era and time of day travel alongside the date stages.
    logic [4:0] era_reg  [0:N-2];
    hms_t       side_reg [0:N-2];

    logic [DAY_W-1:0] z_0;
    logic [44:0]      prod_0;
    logic [DAY_W-1:0] z_0_reg;

    logic [DAY_W-1:0] eo_1;
    logic [17:0]      doe_1_reg;

    logic [36:0] pa_2;
    logic [36:0] pb_2;
    logic [6:0]  a_2_reg;
    logic [2:0]  b_2_reg;
    logic        c_2_reg;
    logic [17:0] doe_2_reg;

    logic [17:0] t_3_reg;
    logic [17:0] doe_3_reg;

    logic [36:0] py_4;
    logic [8:0]  yoe_4_reg;
    logic [17:0] doe_4_reg;

    logic [18:0] p100_5;
    logic [1:0]  y100_5_reg;
    logic [17:0] yd_5_reg;
    logic [8:0]  yoe_5_reg;
    logic [17:0] doe_5_reg;

    logic [17:0] doy_6;
    logic [8:0]  doy_6_reg;
    logic [8:0]  yoe_6_reg;

    logic [10:0] x_7;
    logic [22:0] pm_7;
    logic [3:0]  mp_7_reg;
    logic [8:0]  doy_7_reg;
    logic [8:0]  yoe_7_reg;

    logic              late;
    logic [YEAR_W-1:0] year_8;
    cal_t              out_next;
    cal_t              out_reg;

    always_comb
    begin
        adv[N-1] = !vld_reg[N-1] || !dst_stall;
        for (int i = N - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign src_stall = !adv[0];
    assign dst_valid = vld_reg[N-1];
    assign dst_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= src_valid;
            end
            for (int i = 1; i < N; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // Day number counted from 0000-03-01, split into 400-year eras.
    assign z_0    = src_data.day + Z_OFFSET;
    assign prod_0 = 45'(z_0) * 45'(RECIP_ERA);

    assign eo_1 = 22'(22'(era_reg[0]) * DAYS_PER_ERA);

    assign pa_2 = 37'(doe_1_reg) * 37'(RECIP_1460);
    assign pb_2 = 37'(doe_1_reg) * 37'(RECIP_36524);

    assign py_4 = 37'(t_3_reg) * 37'(RECIP_365);

    assign p100_5 = 19'(yoe_4_reg) * 19'(RECIP_100);

    assign doy_6 = doe_5_reg - (yd_5_reg + 18'(yoe_5_reg[8:2]) - 18'(y100_5_reg));

    assign x_7  = 11'({doy_6_reg, 2'b00}) + 11'(doy_6_reg) + 11'd2;
    assign pm_7 = 23'(x_7) * 23'(RECIP_153);

    // January and February belong to the March-based year before.
    assign late   = (mp_7_reg >= 4'd10);
    assign year_8 = 14'(yoe_7_reg) + 14'(14'(era_reg[N-2]) * 14'd400) + 14'(late);

    always_comb
    begin
        out_next = '0;
        if (side_reg[N-2].ok)
        begin
            out_next.ok     = 1'b1;
            out_next.year   = year_8;
            out_next.month  = late ? (mp_7_reg - 4'd9) : (mp_7_reg + 4'd3);
            out_next.dom    = 5'(doy_7_reg - month_first_doy(mp_7_reg) + 9'd1);
            out_next.hour   = side_reg[N-2].hour;
            out_next.minute = side_reg[N-2].minute;
            out_next.second = side_reg[N-2].second;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            era_reg[0]  <= prod_0[SHIFT_ERA +: 5];
            side_reg[0] <= src_data.hms;
            z_0_reg     <= z_0;
        end
        for (int i = 1; i < N - 1; i++)
        begin
            if (adv[i])
            begin
                era_reg[i]  <= era_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
        if (adv[1])
        begin
            doe_1_reg <= 18'(z_0_reg - eo_1);
        end
        if (adv[2])
        begin
            a_2_reg   <= pa_2[SHIFT_1460 +: 7];
            b_2_reg   <= pb_2[SHIFT_36524 +: 3];
            c_2_reg   <= (doe_1_reg == LAST_DOE);
            doe_2_reg <= doe_1_reg;
        end
        if (adv[3])
        begin
            t_3_reg   <= doe_2_reg - 18'(a_2_reg) + 18'(b_2_reg) - 18'(c_2_reg);
            doe_3_reg <= doe_2_reg;
        end
        if (adv[4])
        begin
            yoe_4_reg <= py_4[SHIFT_365 +: 9];
            doe_4_reg <= doe_3_reg;
        end
        if (adv[5])
        begin
            y100_5_reg <= p100_5[SHIFT_100 +: 2];
            yd_5_reg   <= 18'(yoe_4_reg) * 18'd365;
            yoe_5_reg  <= yoe_4_reg;
            doe_5_reg  <= doe_4_reg;
        end
        if (adv[6])
        begin
            doy_6_reg <= doy_6[8:0];
            yoe_6_reg <= yoe_5_reg;
        end
        if (adv[7])
        begin
            mp_7_reg  <= pm_7[SHIFT_153 +: 4];
            doy_7_reg <= doy_6_reg;
            yoe_7_reg <= yoe_6_reg;
        end
        if (adv[8])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== hdl/unix_seconds_to_calendar_unit.sv =====
`timescale 1ns / 1ps

// Converts signed seconds since 1970-01-01 00:00:00 UTC into the proleptic
// Gregorian date and the time of day.
// Input channel: src_valid / src_stall with unix_seconds (39-bit signed).
// Output channel: dst_valid / dst_stall with valid_res, year, month,
// day_of_month, hour, minute and second. A transaction completes on a rising
// edge where valid is high and stall is low.
// Inputs before 0001-01-01 00:00:00 or after 9999-12-31 23:59:59 give
// valid_res = 0 with every other field zero.
// Three stages split seconds into days and time of day, three derive hour,
// minute and second, and nine turn the day number into year, month and day.
// Throughput is one transaction per cycle while dst_stall is low. Each
// stage holds its own valid bit, so empty stages keep filling while
// dst_stall is high; src_stall rises only once all fifteen stages hold
// work. A stalled result stays unchanged.
// Reset clears all valid bits; the pipeline comes up empty.
module unix_seconds_to_calendar_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                src_valid,
    output logic                                src_stall,
    input  logic signed [ucal_pkg::SECS_W-1:0]  unix_seconds,
    output logic                                dst_valid,
    input  logic                                dst_stall,
    output logic                                valid_res,
    output logic [ucal_pkg::YEAR_W-1:0]         year,
    output logic [ucal_pkg::MONTH_W-1:0]        month,
    output logic [ucal_pkg::DOM_W-1:0]          day_of_month,
    output logic [ucal_pkg::HOUR_W-1:0]         hour,
    output logic [ucal_pkg::MIN_W-1:0]          minute,
    output logic [ucal_pkg::SEC_W-1:0]          second
);
    import ucal_pkg::*;

    logic     split_valid;
    logic     split_stall;
    day_tod_t split_data;
    logic     hms_valid;
    logic     hms_stall;
    day_hms_t hms_data;
    cal_t     cal_data;

    ucal_day_split u_day_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .src_valid    (src_valid),
        .src_stall    (src_stall),
        .unix_seconds (unix_seconds),
        .dst_valid    (split_valid),
        .dst_stall    (split_stall),
        .dst_data     (split_data)
    );

    ucal_hms u_hms (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (split_valid),
        .src_stall (split_stall),
        .src_data  (split_data),
        .dst_valid (hms_valid),
        .dst_stall (hms_stall),
        .dst_data  (hms_data)
    );

    ucal_civil u_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (hms_valid),
        .src_stall (hms_stall),
        .src_data  (hms_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (cal_data)
    );

    assign valid_res    = cal_data.ok;
    assign year         = cal_data.year;
    assign month        = cal_data.month;
    assign day_of_month = cal_data.dom;
    assign hour         = cal_data.hour;
    assign minute       = cal_data.minute;
    assign second       = cal_data.second;

endmodule
